@@ hw/rtl/best_fit_segment_allocator_assert.svh @@
// assertion macros for the segment allocator
`ifndef BEST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BFSA_ASSERT_IMPL(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define BFSA_ASSERT_NEXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define BFSA_ASSERT_IMPL(label, a, c)
`define BFSA_ASSERT_NEXT(label, a, c)
`endif
`endif

@@ hw/rtl/bfsa_pkg.sv @@
`default_nettype none
package bfsa_pkg;
	localparam int SEGMENTS_DEF = 16;
	localparam int MEMORY_UNITS_DEF = 4096;
	localparam int LEN_W = 13;
	localparam int START_W = 12;
	localparam int OWNER_W = 8;
	localparam int STATUS_W = 3;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ZERO = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOID = 3'd4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic op;
		logic [LEN_W-1:0] request_length;
		logic [OWNER_W-1:0] owner_id;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [START_W-1:0] block_start;
		logic [LEN_W-1:0] block_length;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic search;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic done;
	} sts_t;
endpackage
`default_nettype wire

@@ hw/rtl/bfsa_if.sv @@
`default_nettype none
interface bfsa_req_if;
	logic valid;
	logic ready;
	bfsa_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bfsa_rsp_if;
	logic valid;
	logic ready;
	bfsa_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/best_fit_segment_allocator.sv @@
// best fit segment allocator
// req channel: op (0 allocate, 1 release), request_length, owner_id
// rsp channel: status, block_start, block_length; one response per request
// a controller fsm walks the segment table one entry per cycle to find the
// best free fit (allocate) or the lowest used entry of the owner (release),
// then applies a split or merge, if any, in the commit state
// steps: accept, search over the live entries, commit; the response
// then holds until taken
// one request in flight; req ready stays low until the response is taken
// when the receiver stalls, the response holds and no new request is taken
// reset: table holds one free segment covering all memory
`default_nettype none
module best_fit_segment_allocator #(
	parameter int SEGMENTS = bfsa_pkg::SEGMENTS_DEF,
	parameter int MEMORY_UNITS = bfsa_pkg::MEMORY_UNITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	bfsa_req_if.sink req,
	bfsa_rsp_if.source rsp
);
	import bfsa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bfsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.cmd(cmd), .sts(sts)
	);

	bfsa_datapath #(.SEGMENTS(SEGMENTS), .MEMORY_UNITS(MEMORY_UNITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req(req.data), .rsp(rsp.data)
	);
endmodule
`default_nettype wire

@@ hw/rtl/bfsa_ctrl.sv @@
`default_nettype none
module bfsa_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	output bfsa_pkg::cmd_t cmd,
	input wire bfsa_pkg::sts_t sts
);
	import bfsa_pkg::*;
	`include "best_fit_segment_allocator_assert.svh"

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;
	localparam logic [1:0] S_OUT = 2'd3;

	logic [1:0] state_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign cmd.load = in_valid && in_ready;
	assign cmd.search = (state_q == S_SEARCH);
	assign cmd.commit = (state_q == S_COMMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_SEARCH;
				S_SEARCH: if (sts.done) state_q <= S_COMMIT;
				S_COMMIT: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BFSA_ASSERT_NEXT(a_load_search, cmd.load, state_q == S_SEARCH)
	`BFSA_ASSERT_NEXT(a_commit_out, cmd.commit, out_valid)
	`BFSA_ASSERT_IMPL(a_no_overlap, out_valid, !in_ready)
endmodule
`default_nettype wire

@@ hw/rtl/bfsa_datapath.sv @@
`default_nettype none
module bfsa_datapath #(
	parameter int SEGMENTS = bfsa_pkg::SEGMENTS_DEF,
	parameter int MEMORY_UNITS = bfsa_pkg::MEMORY_UNITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire bfsa_pkg::cmd_t cmd,
	output bfsa_pkg::sts_t sts,
	input wire bfsa_pkg::req_t req,
	output bfsa_pkg::rsp_t rsp
);
	import bfsa_pkg::*;
	`include "best_fit_segment_allocator_assert.svh"

	localparam int IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
	localparam int CW = $clog2(SEGMENTS + 1);
	localparam int MW = $clog2(MEMORY_UNITS + 1);
	localparam int WW = (MW > LEN_W) ? MW : LEN_W;

	logic [WW-1:0] start_q [SEGMENTS];
	logic [WW-1:0] len_q [SEGMENTS];
	logic used_q [SEGMENTS];
	logic [OWNER_W-1:0] owner_q [SEGMENTS];
	logic [CW-1:0] count_q;

	req_t req_q;
	logic [IW-1:0] scan_q;
	logic found_q;
	logic [IW-1:0] best_q;
	logic [WW-1:0] best_len_q;
	rsp_t rsp_q;

	logic [WW-1:0] rlen;
	logic [CW-1:0] scan_ext;
	logic last;
	logic hit;

	assign rlen = WW'(req_q.request_length);
	assign scan_ext = CW'(scan_q);
	assign last = (scan_ext + CW'(1) >= count_q);
	assign hit = (req_q.op == OP_ALLOC)
		? (!used_q[scan_q] && len_q[scan_q] >= rlen
			&& (!found_q || len_q[scan_q] <= best_len_q))
		: (used_q[scan_q] && owner_q[scan_q] == req_q.owner_id && !found_q);
	assign sts.done = last;
	assign rsp = rsp_q;

	// commit-time values
	logic [CW-1:0] bi;
	logic prev_free, next_free;
	logic [IW-1:0] bm1, bp1;
	assign bi = CW'(best_q);
	assign bm1 = best_q - IW'(1);
	assign bp1 = best_q + IW'(1);
	assign prev_free = (best_q != '0) && !used_q[bm1];
	assign next_free = (bi + CW'(1) < count_q) && !used_q[bp1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(1);
			for (int k = 0; k < SEGMENTS; k++) begin
				start_q[k] <= '0;
				len_q[k] <= '0;
				used_q[k] <= 1'b0;
				owner_q[k] <= '0;
			end
			len_q[0] <= WW'(MEMORY_UNITS);
			req_q <= '0;
			scan_q <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			best_len_q <= '0;
			rsp_q <= '0;
		end else if (cmd.load) begin
			req_q <= req;
			scan_q <= '0;
			found_q <= 1'b0;
		end else if (cmd.search) begin
			if (hit) begin
				found_q <= 1'b1;
				best_q <= scan_q;
				best_len_q <= len_q[scan_q];
			end
			if (!last) scan_q <= scan_q + IW'(1);
		end else if (cmd.commit) begin
			if (req_q.op == OP_ALLOC) begin
				if (req_q.request_length == '0) begin
					rsp_q <= '{ST_ZERO, '0, '0};
				end else if (!found_q) begin
					rsp_q <= '{ST_NOFIT, '0, '0};
				end else if (best_len_q == rlen) begin
					used_q[best_q] <= 1'b1;
					owner_q[best_q] <= req_q.owner_id;
					rsp_q <= '{ST_OK, START_W'(start_q[best_q]), LEN_W'(rlen)};
				end else if (count_q >= CW'(SEGMENTS)) begin
					rsp_q <= '{ST_FULL, '0, '0};
				end else begin
					for (int k = 1; k < SEGMENTS; k++) begin
						if (CW'(k) > bi + CW'(1) && CW'(k) <= count_q) begin
							start_q[k] <= start_q[k-1];
							len_q[k] <= len_q[k-1];
							used_q[k] <= used_q[k-1];
							owner_q[k] <= owner_q[k-1];
						end
					end
					start_q[bp1] <= start_q[best_q] + rlen;
					len_q[bp1] <= best_len_q - rlen;
					used_q[bp1] <= 1'b0;
					owner_q[bp1] <= '0;
					len_q[best_q] <= rlen;
					used_q[best_q] <= 1'b1;
					owner_q[best_q] <= req_q.owner_id;
					count_q <= count_q + CW'(1);
					rsp_q <= '{ST_OK, START_W'(start_q[best_q]), LEN_W'(rlen)};
				end
			end else if (!found_q) begin
				rsp_q <= '{ST_NOID, '0, '0};
			end else begin
				logic [WW-1:0] ml;
				logic [IW-1:0] dst;
				logic [CW-1:0] gap;
				ml = len_q[best_q];
				if (prev_free) ml = ml + len_q[bm1];
				if (next_free) ml = ml + len_q[bp1];
				dst = prev_free ? bm1 : best_q;
				gap = CW'(prev_free) + CW'(next_free);
				len_q[dst] <= ml;
				used_q[dst] <= 1'b0;
				owner_q[dst] <= '0;
				for (int k = 0; k < SEGMENTS; k++) begin
					if (CW'(k) > CW'(dst) && gap != '0) begin
						if ((CW+1)'(k) + (CW+1)'(gap) < (CW+1)'(count_q)) begin
							if (gap == CW'(2)) begin
								start_q[k] <= start_q[(k+2) % SEGMENTS];
								len_q[k] <= len_q[(k+2) % SEGMENTS];
								used_q[k] <= used_q[(k+2) % SEGMENTS];
								owner_q[k] <= owner_q[(k+2) % SEGMENTS];
							end else begin
								start_q[k] <= start_q[(k+1) % SEGMENTS];
								len_q[k] <= len_q[(k+1) % SEGMENTS];
								used_q[k] <= used_q[(k+1) % SEGMENTS];
								owner_q[k] <= owner_q[(k+1) % SEGMENTS];
							end
						end else if (CW'(k) < count_q) begin
							start_q[k] <= '0;
							len_q[k] <= '0;
							used_q[k] <= 1'b0;
							owner_q[k] <= '0;
						end
					end
				end
				count_q <= count_q - gap;
				rsp_q <= '{ST_OK, START_W'(start_q[dst]), LEN_W'(ml)};
			end
		end
	end

	`BFSA_ASSERT_IMPL(a_count_range, 1'b1, count_q >= CW'(1) && count_q <= CW'(SEGMENTS))
	`BFSA_ASSERT_IMPL(a_scan_range, cmd.search, scan_ext < count_q)
	`BFSA_ASSERT_NEXT(a_ok_nonzero, cmd.commit && req_q.op == OP_ALLOC && found_q
		&& req_q.request_length != '0, rsp_q.status != ST_NOFIT)
endmodule
`default_nettype wire
